// File: rtl/sbb_pkg.sv
// Package for the Sauvola tile binarizer: sizes, codes and shared structs.
// No dependencies; every other rtl file refers to it by scoped names.
package sbb_pkg;

  localparam int TILE_SIDE = 8;
  localparam int TILE_CAP  = TILE_SIDE * TILE_SIDE;
  localparam int CNT_W     = 7;   // pixel count, holds TILE_CAP
  localparam int IDX_W     = 6;   // index into one bank
  localparam int ADDR_W    = IDX_W + 1;   // bank bit + index
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 14;
  localparam int SQS_W     = 22;
  localparam int K_W       = 9;
  localparam int R_W       = 8;
  localparam int NQ_W      = CNT_W + SQS_W;   // n*Q
  localparam int SS_W      = 2 * SUM_W;       // S*S
  localparam int D_W       = 30;              // even width for the root
  localparam int ROOT_W    = D_W / 2;
  localparam int RREM_W    = ROOT_W + 2;
  localparam int NR_W      = CNT_W + R_W;     // n*R
  localparam int NN_W      = 2 * CNT_W;       // n*n
  localparam int P_W       = 25;
  localparam int KR_W      = K_W + ROOT_W;
  localparam int KNR_W     = K_W + NR_W;
  localparam int NNR_W     = NN_W + R_W;
  localparam int PROD_W    = SUM_W + P_W;     // dividend width
  localparam int STEP_W    = 6;               // holds PROD_W

  // configuration register indexes
  localparam logic REG_K_GAIN = 1'b0;
  localparam logic REG_RANGE  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
    logic [SQS_W-1:0] sqs;
    logic             bank;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_t;

endpackage

// File: rtl/sbb_if.sv
// Handshake interfaces for the pixel input and the binary result output.
// Depends on sbb_pkg.
interface sbb_pix_if;
  logic                     valid;
  logic                     ready;
  logic [sbb_pkg::PIX_W-1:0] intensity;
  logic                     tile_end;
  modport source (output valid, output intensity, output tile_end, input ready);
  modport sink   (input valid, input intensity, input tile_end, output ready);
endinterface

interface sbb_res_if;
  logic valid;
  logic ready;
  logic is_white;
  logic last_out;
  modport source (output valid, output is_white, output last_out, input ready);
  modport sink   (input valid, input is_white, input last_out, output ready);
endinterface

// File: rtl/sbb_front.sv
// Front end: accepts pixel words, writes them to the tile store, accumulates
// sum / sum of squares / count and hands a tile descriptor on. Uses sbb_pkg.
module sbb_front (
  input  logic           clk,
  input  logic           rst,
  sbb_pix_if.sink        pix,
  output sbb_pkg::desc_t desc,
  output logic           push,
  input  logic           desc_ready,
  input  logic           tile_done,
  output sbb_pkg::wr_t   wr
);

  logic [sbb_pkg::CNT_W-1:0] cnt;
  logic [sbb_pkg::SUM_W-1:0] sum;
  logic [sbb_pkg::SQS_W-1:0] sqs;
  logic                      bank;
  logic [1:0]                in_use;   // banks holding a tile not yet emitted
  logic                      accept;
  logic                      last_pix;
  logic [sbb_pkg::CNT_W-1:0] cnt_next;
  logic [sbb_pkg::SUM_W-1:0] sum_next;
  logic [sbb_pkg::SQS_W-1:0] sqs_next;
  logic [2*sbb_pkg::PIX_W-1:0] pix_sq;

  assign pix.ready = (in_use != 2'd2) && desc_ready;
  assign accept    = pix.valid && pix.ready;

  assign pix_sq   = pix.intensity * pix.intensity;
  assign cnt_next = cnt + 1'b1;
  assign sum_next = sum + sbb_pkg::SUM_W'(pix.intensity);
  assign sqs_next = sqs + sbb_pkg::SQS_W'(pix_sq);
  assign last_pix = pix.tile_end || (cnt_next == sbb_pkg::CNT_W'(sbb_pkg::TILE_CAP));
  assign push     = accept && last_pix;

  // descriptor of the tile that closes with this word
  assign desc.n    = cnt_next;
  assign desc.sum  = sum_next;
  assign desc.sqs  = sqs_next;
  assign desc.bank = bank;

  // store write
  assign wr.en   = accept;
  assign wr.addr = {bank, cnt[sbb_pkg::IDX_W-1:0]};
  assign wr.data = pix.intensity;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      sum    <= '0;
      sqs    <= '0;
      bank   <= 1'b0;
      in_use <= 2'd0;
    end else begin
      if (accept) begin
        if (last_pix) begin
          cnt  <= '0;
          sum  <= '0;
          sqs  <= '0;
          bank <= ~bank;
        end else begin
          cnt <= cnt_next;
          sum <= sum_next;
          sqs <= sqs_next;
        end
      end
      in_use <= in_use + {1'b0, push} - {1'b0, tile_done};
    end
  end

endmodule

// File: rtl/sbb_desc_fifo.sv
// Two-entry queue of tile descriptors between front and back end.
// Uses sbb_pkg::desc_t.
module sbb_desc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbb_pkg::desc_t din,
  output logic           not_full,
  input  logic           pop,
  output sbb_pkg::desc_t dout,
  output logic           not_empty
);

  sbb_pkg::desc_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign dout      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (not_full || pop)) else $error("descriptor queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("descriptor queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("descriptor queue count out of range");

endmodule

// File: rtl/sbb_back.sv
// Back end: tile store, threshold sequencer (root and divide one step per
// cycle) and pixel emission. Uses sbb_pkg and sbb_res_if.
module sbb_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sbb_pkg::wr_t              wr,
  input  sbb_pkg::desc_t            desc,
  input  logic                      desc_valid,
  output logic                      pop,
  input  logic [sbb_pkg::K_W-1:0]   k_gain,
  input  logic [sbb_pkg::R_W-1:0]   range_eff,
  output logic                      tile_done,
  sbb_res_if.source                 res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_SUB  = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state;

  // tile store, two banks
  logic [sbb_pkg::PIX_W-1:0]  mem [2**sbb_pkg::ADDR_W];
  logic [sbb_pkg::PIX_W-1:0]  rdata;
  logic [sbb_pkg::ADDR_W-1:0] raddr;

  sbb_pkg::desc_t             cur;
  logic [sbb_pkg::NQ_W-1:0]   nq;
  logic [sbb_pkg::SS_W-1:0]   ss;
  logic [sbb_pkg::NR_W-1:0]   nr;
  logic [sbb_pkg::NN_W-1:0]   nn;
  logic [sbb_pkg::D_W-1:0]    rx;
  logic [sbb_pkg::RREM_W-1:0] rrem;
  logic [sbb_pkg::ROOT_W-1:0] root;
  logic [sbb_pkg::STEP_W-1:0] step;
  logic [sbb_pkg::KR_W-1:0]   kr;
  logic [sbb_pkg::KNR_W-1:0]  knr;
  logic [sbb_pkg::NNR_W-1:0]  nnr;
  logic [sbb_pkg::NR_W+7:0]   n256r;
  logic [sbb_pkg::P_W-1:0]    pm;
  logic                       all_white;
  logic [sbb_pkg::PROD_W-1:0] dvd;
  logic [sbb_pkg::PROD_W-1:0] quo;
  logic [sbb_pkg::NNR_W-1:0]  drem;
  logic [sbb_pkg::IDX_W-1:0]  idx;

  logic [sbb_pkg::RREM_W+1:0] r_sh;
  logic [sbb_pkg::RREM_W+1:0] r_trial;
  logic [sbb_pkg::NNR_W:0]    d_sh;
  logic [sbb_pkg::P_W-1:0]    p_sum;
  logic [sbb_pkg::PROD_W-1:0] pix_q8;
  logic                       is_last;

  // store: write from the front, registered read here
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (state == S_RD) begin
      rdata <= mem[raddr];
    end
  end

  assign raddr = {cur.bank, idx};

  // one digit of the square root
  assign r_sh    = {rrem, rx[sbb_pkg::D_W-1 -: 2]};
  assign r_trial = {2'b00, root, 2'b01};
  // one bit of the division
  assign d_sh    = {drem, dvd[sbb_pkg::PROD_W-1]};
  // P = 256*n*R + k*r
  assign p_sum   = sbb_pkg::P_W'(n256r) + sbb_pkg::P_W'(kr);

  assign pix_q8  = sbb_pkg::PROD_W'({rdata, 8'h00});
  assign is_last = ({1'b0, idx} + 1'b1) == cur.n;

  assign pop          = (state == S_IDLE) && desc_valid;
  assign res.valid    = (state == S_OUT);
  assign res.is_white = all_white || (pix_q8 > quo);
  assign res.last_out = is_last;
  assign tile_done    = (state == S_OUT) && res.ready && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (desc_valid) begin
            cur   <= desc;
            state <= S_MUL1;
          end
        end
        // products of the count with the sums, the range and itself, and the sum squared
        S_MUL1: begin
          nq    <= cur.n * cur.sqs;
          ss    <= cur.sum * cur.sum;
          nr    <= cur.n * range_eff;
          nn    <= cur.n * cur.n;
          state <= S_DIFF;
        end
        // variance numerator, clamped at zero
        S_DIFF: begin
          rx    <= (sbb_pkg::SS_W'(nq) > ss || nq[sbb_pkg::NQ_W-1])
                   ? sbb_pkg::D_W'(nq - sbb_pkg::NQ_W'(ss)) : '0;
          rrem  <= '0;
          root  <= '0;
          step  <= '0;
          state <= S_SQRT;
        end
        // restoring square root, two bits a cycle
        S_SQRT: begin
          rx <= rx << 2;
          if (r_sh >= r_trial) begin
            rrem <= sbb_pkg::RREM_W'(r_sh - r_trial);
            root <= {root[sbb_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rrem <= sbb_pkg::RREM_W'(r_sh);
            root <= {root[sbb_pkg::ROOT_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == sbb_pkg::STEP_W'(sbb_pkg::ROOT_W - 1)) state <= S_MUL2;
        end
        S_MUL2: begin
          kr    <= k_gain * root;
          knr   <= k_gain * nr;
          nnr   <= nn * range_eff;
          n256r <= {nr, 8'h00};
          state <= S_SUB;
        end
        // negative threshold makes the whole tile white
        S_SUB: begin
          all_white <= p_sum < sbb_pkg::P_W'(knr);
          pm        <= p_sum - sbb_pkg::P_W'(knr);
          state     <= S_MUL3;
        end
        S_MUL3: begin
          dvd   <= cur.sum * pm;
          quo   <= '0;
          drem  <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        // restoring divide S*(P-M) / (n*n*R), one bit a cycle
        S_DIV: begin
          dvd <= dvd << 1;
          if (d_sh >= {1'b0, nnr}) begin
            drem <= sbb_pkg::NNR_W'(d_sh - {1'b0, nnr});
            quo  <= {quo[sbb_pkg::PROD_W-2:0], 1'b1};
          end else begin
            drem <= sbb_pkg::NNR_W'(d_sh);
            quo  <= {quo[sbb_pkg::PROD_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == sbb_pkg::STEP_W'(sbb_pkg::PROD_W - 1)) begin
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        // hold the result word until taken
        S_OUT: begin
          if (res.ready) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_MUL1)) else $error("descriptor taken outside idle");
  a_root_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) && (step == sbb_pkg::STEP_W'(sbb_pkg::ROOT_W - 1)) |=> (state == S_MUL2))
    else $error("square root did not finish on count");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> ({1'b0, idx} < cur.n)) else $error("emit index past tile");

endmodule

// File: rtl/sauvola_block_binarizer_core.sv
// Top level of the Sauvola tile binarizer: config registers, front end,
// descriptor queue and back end. Depends on sbb_pkg, sbb_if and submodules.
//
//  port      dir  handshake      payload
//  in_pix    in   valid/ready    intensity[7:0], tile_end
//  out_res   out  valid/ready    is_white, last_out
//  cfg_*     in   cfg_we         cfg_index (0 k_gain_q8, 1 dynamic_range), cfg_data[8:0]
//
// Loading accepts one pixel per cycle unless input is stalled. At tile end the
// back end computes the threshold (15-step root, 39-step divide) and then
// emits each pixel by a store read and an output hold until taken. Two store
// banks let the next tile load while the previous one is emitted; input stalls
// only when both banks hold tiles. Reset is synchronous on rst; no clearing pass.
module sauvola_block_binarizer_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [sbb_pkg::K_W-1:0] cfg_data,
  sbb_pix_if.sink                 in_pix,
  sbb_res_if.source               out_res
);

  logic [sbb_pkg::K_W-1:0] k_gain_q8;
  logic [sbb_pkg::R_W-1:0] dynamic_range;
  logic [sbb_pkg::R_W-1:0] range_eff;

  sbb_pkg::desc_t f_desc;
  sbb_pkg::desc_t q_desc;
  sbb_pkg::wr_t   wr;
  logic           push;
  logic           q_not_full;
  logic           q_not_empty;
  logic           pop;
  logic           tile_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_gain_q8     <= sbb_pkg::K_W'(128);
      dynamic_range <= sbb_pkg::R_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbb_pkg::REG_K_GAIN: k_gain_q8     <= cfg_data;
        sbb_pkg::REG_RANGE:  dynamic_range <= cfg_data[sbb_pkg::R_W-1:0];
        default: ;
      endcase
    end
  end

  // zero range counts as one
  assign range_eff = (dynamic_range == '0) ? sbb_pkg::R_W'(1) : dynamic_range;

  sbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (in_pix),
    .desc       (f_desc),
    .push       (push),
    .desc_ready (q_not_full),
    .tile_done  (tile_done),
    .wr         (wr)
  );

  sbb_desc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (f_desc),
    .not_full  (q_not_full),
    .pop       (pop),
    .dout      (q_desc),
    .not_empty (q_not_empty)
  );

  sbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .desc       (q_desc),
    .desc_valid (q_not_empty),
    .pop        (pop),
    .k_gain     (k_gain_q8),
    .range_eff  (range_eff),
    .tile_done  (tile_done),
    .res        (out_res)
  );

endmodule

// File: tb/tb_sauvola_block_binarizer_core.sv
// Testbench for the Sauvola tile binarizer: pixel tiles in, binary words out,
// checked against a behavioral threshold predictor. Depends on sbb_pkg, sbb_if, rtl.
`timescale 1ns / 1ps

module tb_sauvola_block_binarizer_core;

  typedef struct packed {
    logic [7:0] pix;
    logic       tile_end;
  } pix_word_t;

  typedef struct packed {
    logic is_white;
    logic last_out;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = sbb_pkg::REG_K_GAIN;
  logic [sbb_pkg::K_W-1:0] cfg_data = '0;

  sbb_pix_if in_pix();
  sbb_res_if out_res();

  sauvola_block_binarizer_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_pix(in_pix), .out_res(out_res)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  tile_pix [64];
  logic [6:0]  acc_n;
  logic [13:0] acc_sum;
  logic [21:0] acc_sqs;
  logic [8:0]  k_gain;
  logic [7:0]  range_r;

  pix_word_t pending_pix[$];
  bin_word_t expected_bits[$];
  int  errors = 0, checked = 0, tiles = 0, in_count = 0;
  bit  drive_idle_ok = 1, sink_idle_ok = 1;
  longint cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  // accumulate one pixel; at tile end push its binarized words
  task automatic binarize_pixel(pix_word_t w);
    longint unsigned n, s, q, d, r, rr, k, p, m, t8;
    bit all_white;
    tile_pix[acc_n[5:0]] = w.pix;
    acc_n   = acc_n + 7'd1;
    acc_sum = acc_sum + w.pix;
    acc_sqs = acc_sqs + 22'(w.pix) * 22'(w.pix);
    if (!w.tile_end && acc_n < sbb_pkg::TILE_CAP) return;
    n = acc_n; s = acc_sum; q = acc_sqs;
    d = (n * q > s * s) ? n * q - s * s : 0;
    r = isqrt(d);
    rr = (range_r != 0) ? range_r : 1;
    k = k_gain;
    p = 256 * n * rr + k * r;
    m = k * n * rr;
    all_white = p < m;
    t8 = all_white ? 0 : (s * (p - m)) / (n * n * rr);
    for (int i = 0; i < n; i++)
      expected_bits.push_back('{is_white: all_white || (256 * longint'(tile_pix[i]) > t8),
                                last_out: (i + 1 == n)});
    tiles++;
    acc_n = 0; acc_sum = 0; acc_sqs = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_pix.valid <= 1'b0;
      in_pix.intensity <= '0;
      in_pix.tile_end <= 1'b0;
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        binarize_pixel('{pix: in_pix.intensity, tile_end: in_pix.tile_end});
        in_count++;
      end
      if (!in_pix.valid || in_pix.ready) begin
        if (pending_pix.size() > 0 && !(drive_idle_ok && $urandom_range(99) < 30)) begin
          pix_word_t w;
          w = pending_pix.pop_front();
          in_pix.valid <= 1'b1;
          in_pix.intensity <= w.pix;
          in_pix.tile_end <= w.tile_end;
        end else in_pix.valid <= 1'b0;
      end
    end
  end

  // monitor with random backpressure
  always @(posedge clk) begin
    if (rst) out_res.ready <= 1'b0;
    else begin
      if (out_res.valid && out_res.ready) begin
        if (expected_bits.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: white=%0b last=%0b",
                                     out_res.is_white, out_res.last_out);
        end else begin
          bin_word_t e;
          e = expected_bits.pop_front();
          checked++;
          if (e.is_white !== out_res.is_white || e.last_out !== out_res.last_out) begin
            errors++;
            if (errors <= 10)
              $display("mismatch word %0d: exp white=%0b last=%0b got white=%0b last=%0b",
                       checked, e.is_white, e.last_out, out_res.is_white, out_res.last_out);
          end
        end
      end
      out_res.ready <= !(sink_idle_ok && $urandom_range(99) < 30);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout with %0d words outstanding", expected_bits.size());
      $display("tb_sauvola_block_binarizer_core: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [sbb_pkg::K_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sbb_pkg::REG_K_GAIN) k_gain = val; else range_r = val[7:0];
  endtask

  // wait for every queued pixel and expected word, then drain the pipeline
  task automatic wait_drained();
    while (pending_pix.size() > 0 || in_pix.valid || expected_bits.size() > 0 || acc_n != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic queue_tile(int len, int mode);
    for (int i = 0; i < len; i++) begin
      pix_word_t w;
      case (mode)
        0: w.pix = $urandom_range(255);
        1: w.pix = (i % 2) ? 8'd255 : 8'd0;
        2: w.pix = 8'(96 + $urandom_range(40));
        default: w.pix = $urandom_range(1) ? 8'(200 + $urandom_range(55)) : 8'($urandom_range(50));
      endcase
      w.tile_end = (i == len - 1) && (len < sbb_pkg::TILE_CAP || $urandom_range(1));
      pending_pix.push_back(w);
    end
  endtask

  initial begin
    acc_n = 0; acc_sum = 0; acc_sqs = 0;
    k_gain = 9'd128; range_r = 8'd128;
    in_pix.valid = 1'b0; in_pix.intensity = '0; in_pix.tile_end = 1'b0;
    out_res.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: single-pixel extremes, flat and contrasting tiles
    pending_pix.push_back('{pix: 8'd0, tile_end: 1'b1});
    pending_pix.push_back('{pix: 8'd255, tile_end: 1'b1});
    for (int i = 0; i < 4; i++) pending_pix.push_back('{pix: 8'd77, tile_end: i == 3});
    queue_tile(6, 1);
    wait_drained();

    // k of one and range one on a high-contrast tile push the threshold above every pixel
    write_reg(sbb_pkg::REG_K_GAIN, 9'd256);
    write_reg(sbb_pkg::REG_RANGE, 8'd1);
    queue_tile(8, 1);
    wait_drained();
    write_reg(sbb_pkg::REG_K_GAIN, 9'd0);
    write_reg(sbb_pkg::REG_RANGE, 8'd0);   // zero range acts as one
    queue_tile(5, 0);
    wait_drained();

    // random phases; the first runs without idling, the last fills one tile to capacity
    for (int ph = 0; ph < 4; ph++) begin
      drive_idle_ok = (ph != 0);
      sink_idle_ok  = (ph != 0);
      if (ph == 1) write_reg(sbb_pkg::REG_RANGE, 8'd255);
      if (ph == 2) begin
        write_reg(sbb_pkg::REG_K_GAIN, 9'd511);
        write_reg(sbb_pkg::REG_RANGE, 8'($urandom_range(1, 255)));
      end
      if (ph == 3) begin
        write_reg(sbb_pkg::REG_K_GAIN, 9'($urandom_range(256)));
        write_reg(sbb_pkg::REG_RANGE, 8'd128);
      end
      if (ph < 3)
        repeat (4) queue_tile($urandom_range(1, 6), $urandom_range(3));
      else
        queue_tile(sbb_pkg::TILE_CAP, 3);   // forced tile end at capacity
      wait_drained();
    end

    $display("covered %0d pixels in %0d tiles, %0d result words checked",
             in_count, tiles, checked);
    if (errors == 0) $display("tb_sauvola_block_binarizer_core: PASS");
    else begin
      $display("%0d mismatches", errors);
      $display("tb_sauvola_block_binarizer_core: FAIL");
    end
    $finish;
  end
endmodule
